FILE: rtl/bcd_pkg.sv
// Shared types, constants and arithmetic helpers for the BC1/BC3 block decoder.
`default_nettype none

package bcd_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_FORMAT = '0;

    localparam logic FMT_BC1 = 1'b0;
    localparam logic FMT_BC3 = 1'b1;

    // Palette queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0]  ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'd0;
    localparam logic [3:0]  TEXEL_LAST   = 4'd15;

    // Reciprocals for constant division
    localparam logic [9:0]  RECIP3 = 10'd683;   // /3 as *683 >> 11
    localparam logic [11:0] RECIP7 = 12'd2341;  // /7 as *2341 >> 14
    localparam logic [11:0] RECIP5 = 12'd3277;  // /5 as *3277 >> 14

    typedef struct packed {
        logic [63:0] alpha_block;
        logic [63:0] color_block;
    } blk_t;

    typedef struct packed {
        logic [3:0]  texel_index;
        logic [31:0] texel_rgba;
        logic        last_texel;
    } texel_t;

    // Decoded block: full palettes plus the per-texel indices
    typedef struct packed {
        logic [3:0][23:0] color;
        logic [7:0][7:0]  alpha;
        logic [31:0]      cidx;
        logic [47:0]      aidx;
    } pal_t;

    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [13:0] t;
        logic [13:0] s;
        t = {1'b0, v, 8'b0} - {9'b0, v} + 14'd16;
        s = (t >> 5) + t;
        return s[12:5];
    endfunction

    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [14:0] t;
        logic [14:0] s;
        t = {1'b0, v, 8'b0} - {9'b0, v} + 15'd32;
        s = (t >> 6) + t;
        return s[13:6];
    endfunction

    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = x * RECIP3;
        return p[18:11];
    endfunction

    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = x * RECIP7;
        return p[21:14];
    endfunction

    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = x * RECIP5;
        return p[21:14];
    endfunction

    // Weighted endpoint sum for alpha code c (2..7); divided later
    function automatic logic [10:0] alpha_sum(input logic [7:0] a0, input logic [7:0] a1,
                                              input logic [2:0] c, input logic gt);
        logic [2:0] w0;
        logic [2:0] w1;
        w1 = c - 3'd1;
        if (gt)
            w0 = 3'd0 - c;          // 8 - c, modulo 8
        else if (c < 3'd6)
            w0 = 3'd6 - c;
        else
        begin
            w0 = 3'd0;
            w1 = 3'd0;
        end
        return 11'(w0) * 11'(a0) + 11'(w1) * 11'(a1);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bc1_bc3_block_decoder.sv
// Top level of the BC1/BC3 texture block decoder: config register and datapath wiring.
`default_nettype none

// Decodes one compressed 4x4 block per request into sixteen RGBA8 texels, emitted in
// row-major order, one per cycle while a palette is queued and texel_ready holds, with
// last_texel marking texel 15. The output channel sets the pace: a block occupies the
// texel walker through all sixteen texels while the front end decodes the next block's
// palette and parks it in a two-entry queue. The first texel passes through the front
// stage register, a queue entry and the output register, in that order, before it is
// valid. block_format (address 0, bit 0) picks BC1 (0) or BC3 (1); it is sampled when
// a block is accepted, so change it only with the decoder idle. In BC1 mode alpha_block
// is ignored and every texel has alpha 255.

module bc1_bc3_block_decoder (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // APB-style configuration port
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [bcd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    // block requests
    input  wire logic                         blk_valid,
    output logic                              blk_ready,
    input  wire bcd_pkg::blk_t                blk,
    // texel results
    output logic                              texel_valid,
    input  wire logic                         texel_ready,
    output bcd_pkg::texel_t                   texel
);
    import bcd_pkg::*;

    logic                 fmt_reg;
    logic                 fmt_next;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic                 cfg_write;

    logic fq_valid;
    logic fq_ready;
    pal_t fq_data;
    logic qb_valid;
    logic qb_ready;
    pal_t qb_data;

    // Register access: word index from the byte address, low two bits ignored
    assign reg_idx   = paddr[CFG_ADDR_W-1:2];
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        fmt_next = fmt_reg;
        if (cfg_write && reg_idx == REG_BLOCK_FORMAT)
            fmt_next = pwdata[0];
    end

    always_comb
    begin
        case (reg_idx)
            REG_BLOCK_FORMAT: prdata = {31'b0, fmt_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= FMT_BC1;
        else
            fmt_reg <= fmt_next;
    end

    // Front end: endpoint widening and palette build
    bcd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt       (fmt_reg),
        .blk_valid (blk_valid),
        .blk_ready (blk_ready),
        .blk       (blk),
        .pal_valid (fq_valid),
        .pal_ready (fq_ready),
        .pal       (fq_data)
    );

    // Decoupling queue so the front can run ahead of the texel walk
    bcd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // Back end: one texel per cycle into the output register while texel_ready holds
    bcd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pal_valid   (qb_valid),
        .pal_ready   (qb_ready),
        .pal         (qb_data),
        .texel_valid (texel_valid),
        .texel_ready (texel_ready),
        .texel       (texel)
    );

endmodule

`default_nettype wire

FILE: rtl/bcd_front.sv
// Front end: accepts blocks, widens endpoints, builds color and alpha palettes.
`default_nettype none

module bcd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          fmt,
    input  wire logic          blk_valid,
    output logic               blk_ready,
    input  wire bcd_pkg::blk_t blk,
    output logic               pal_valid,
    input  wire logic          pal_ready,
    output bcd_pkg::pal_t      pal
);
    import bcd_pkg::*;

    typedef struct packed {
        logic             bc3;
        logic             four;
        logic [2:0][7:0]  e0;
        logic [2:0][7:0]  e1;
        logic [7:0]       a0;
        logic [7:0]       a1;
        logic             agt;
        logic [5:0][10:0] asum;
        logic [31:0]      cidx;
        logic [47:0]      aidx;
    } fe_t;

    fe_t  st_reg;
    fe_t  st_next;
    logic st_valid_reg;
    logic st_valid_next;
    logic accept;

    assign blk_ready = !st_valid_reg || pal_ready;
    assign accept    = blk_valid && blk_ready;

    // Stage 1: endpoint widening and alpha weighted sums
    always_comb
    begin
        logic [15:0] c0;
        logic [15:0] c1;
        c0 = blk.color_block[15:0];
        c1 = blk.color_block[31:16];
        st_next.bc3   = (fmt == FMT_BC3);
        st_next.four  = (fmt == FMT_BC3) || (c0 > c1);
        st_next.e0[0] = widen5(c0[15:11]);
        st_next.e0[1] = widen6(c0[10:5]);
        st_next.e0[2] = widen5(c0[4:0]);
        st_next.e1[0] = widen5(c1[15:11]);
        st_next.e1[1] = widen6(c1[10:5]);
        st_next.e1[2] = widen5(c1[4:0]);
        st_next.a0    = blk.alpha_block[7:0];
        st_next.a1    = blk.alpha_block[15:8];
        st_next.agt   = blk.alpha_block[7:0] > blk.alpha_block[15:8];
        for (int c = 2; c < 8; c++)
            st_next.asum[c-2] = alpha_sum(blk.alpha_block[7:0], blk.alpha_block[15:8],
                                          3'(c), blk.alpha_block[7:0] > blk.alpha_block[15:8]);
        st_next.cidx  = blk.color_block[63:32];
        st_next.aidx  = blk.alpha_block[63:16];
    end

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
            st_valid_next = 1'b1;
        else if (pal_ready)
            st_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_valid_reg <= 1'b0;
        else
            st_valid_reg <= st_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            st_reg <= st_next;
    end

    // Stage 2: interpolated palette entries
    assign pal_valid = st_valid_reg;

    always_comb
    begin
        logic [9:0] x2;
        logic [9:0] x3;
        logic [8:0] mid;
        pal.cidx     = st_reg.cidx;
        pal.aidx     = st_reg.aidx;
        pal.color[0] = st_reg.e0;
        pal.color[1] = st_reg.e1;
        pal.color[2] = '0;
        pal.color[3] = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            x2  = {1'b0, st_reg.e0[ch], 1'b0} + {2'b0, st_reg.e1[ch]};
            x3  = {2'b0, st_reg.e0[ch]} + {1'b0, st_reg.e1[ch], 1'b0};
            mid = {1'b0, st_reg.e0[ch]} + {1'b0, st_reg.e1[ch]};
            if (st_reg.four)
            begin
                pal.color[2][ch*8 +: 8] = div3(x2);
                pal.color[3][ch*8 +: 8] = div3(x3);
            end
            else
            begin
                pal.color[2][ch*8 +: 8] = mid[8:1];
                pal.color[3][ch*8 +: 8] = 8'd0;
            end
        end

        pal.alpha[0] = st_reg.a0;
        pal.alpha[1] = st_reg.a1;
        for (int c = 2; c < 8; c++)
        begin
            if (st_reg.agt)
                pal.alpha[c] = div7(st_reg.asum[c-2]);
            else if (c == 6)
                pal.alpha[c] = ALPHA_CLEAR;
            else if (c == 7)
                pal.alpha[c] = ALPHA_OPAQUE;
            else
                pal.alpha[c] = div5(st_reg.asum[c-2]);
        end
        if (!st_reg.bc3)
            pal.alpha = {8{ALPHA_OPAQUE}};
    end

endmodule

`default_nettype wire

FILE: rtl/bcd_queue.sv
// Short FIFO of decoded palettes between the front and back ends.
`default_nettype none

module bcd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire bcd_pkg::pal_t push_data,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output bcd_pkg::pal_t      pop_data
);
    import bcd_pkg::*;

    pal_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              push;
    logic              pop;

    assign push_ready = (cnt_reg != QCNT_W'(QDEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("queue count above depth");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 1'b1))
        else $error("queue count missed a push");

    a_cnt_down: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !push) |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("queue count missed a pop");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 || cnt_reg == QCNT_W'(QDEPTH)) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

FILE: rtl/bcd_back.sv
// Back end: walks the sixteen texels of a decoded block into the output register.
`default_nettype none

module bcd_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pal_valid,
    output logic               pal_ready,
    input  wire bcd_pkg::pal_t pal,
    output logic               texel_valid,
    input  wire logic          texel_ready,
    output bcd_pkg::texel_t    texel
);
    import bcd_pkg::*;

    logic [3:0] cnt_reg;
    logic [3:0] cnt_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    texel_t     out_reg;
    texel_t     out_next;
    logic       load;
    logic [1:0] ci;
    logic [2:0] ai;

    assign load      = pal_valid && (!out_valid_reg || texel_ready);
    assign pal_ready = load && (cnt_reg == TEXEL_LAST);

    assign ci = pal.cidx[{cnt_reg, 1'b0} +: 2];
    assign ai = pal.aidx[6'(cnt_reg) * 6'd3 +: 3];

    always_comb
    begin
        out_next.texel_index = cnt_reg;
        out_next.texel_rgba  = {pal.alpha[ai], pal.color[ci]};
        out_next.last_texel  = (cnt_reg == TEXEL_LAST);
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            cnt_next       = cnt_reg + 1'b1;
            out_valid_next = 1'b1;
        end
        else if (texel_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= out_next;
    end

    assign texel_valid = out_valid_reg;
    assign texel       = out_reg;

endmodule

`default_nettype wire
